### hdl/uvt_pkg.sv
// shared types and constants for the unsorted value table
`timescale 1ns / 1ps

package uvt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 2;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int FILL_W   = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_CONTAINS = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST_RD,
		S_MOVE,
		S_FINISH
	} state_t;

endpackage

### hdl/uvt_req_if.sv
// request channel: operation and value
`timescale 1ns / 1ps

interface uvt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [uvt_pkg::OP_W-1:0]             operation;
	logic signed [uvt_pkg::VAL_W-1:0]     value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

### hdl/uvt_rsp_if.sv
// response channel: status and fill count
`timescale 1ns / 1ps

interface uvt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [uvt_pkg::STAT_W-1:0]        status;
	logic [uvt_pkg::FILL_W-1:0]        fill_count;

	modport source (output valid, output status, output fill_count, input ready);
	modport sink   (input valid, input status, input fill_count, output ready);
endinterface

### hdl/uvt_ram.sv
// single write port, single registered read port ram
`timescale 1ns / 1ps

module uvt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/unsorted_value_table_unit.sv
// top level of the unsorted value table: sequencer, fill count and response register
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------
//  req     | in  | valid/ready | operation [1:0], value [31:0] signed
//  rsp     | out | valid/ready | status [1:0], fill_count [4:0]
//
// add and clear go straight from idle to finish; contains and remove scan the valid entries
// in order and the scan ends at the first hit; a remove that moves the last entry into
// the hole reads it in the last-read state and writes it in the move state
// the scan issues one ram read per cycle; the single read port sets the rate
// reset clears the count and the sequencer; the entry ram keeps its contents
// a new request is taken while a response still waits; a finished item holds in
// its last state until the response register is free
`timescale 1ns / 1ps

module unsorted_value_table_unit (
	input  logic         clk,
	input  logic         arst_n,
	uvt_req_if.sink      req,
	uvt_rsp_if.source    rsp
);

	// sequencer state
	uvt_pkg::state_t state_q, state_d;

	// latched request
	uvt_pkg::op_t                      op_q;
	logic [uvt_pkg::VAL_W-1:0]         key_q;

	// table count and scan position
	logic [uvt_pkg::CNT_W-1:0]         count_q;
	logic [uvt_pkg::CNT_W-1:0]         scan_q;
	logic [uvt_pkg::IDX_W-1:0]         pos_q;
	uvt_pkg::status_t                  status_q;

	// read in flight: data for pend_idx_s1 shows up this cycle
	logic                              pend_s1;
	logic [uvt_pkg::IDX_W-1:0]         pend_idx_s1;

	// response register
	logic                              rsp_valid_q;
	uvt_pkg::status_t                  rsp_status_q;
	logic [uvt_pkg::FILL_W-1:0]        rsp_fill_q;

	// ram ports
	logic                              wr_en;
	logic [uvt_pkg::IDX_W-1:0]         wr_addr;
	logic [uvt_pkg::VAL_W-1:0]         wr_data;
	logic [uvt_pkg::IDX_W-1:0]         rd_addr;
	logic [uvt_pkg::VAL_W-1:0]         rd_data;

	logic                              req_xfer;
	logic                              issue;
	logic                              hit;
	logic                              hit_last;
	logic                              full;
	logic                              rsp_free;
	logic [uvt_pkg::CNT_W-1:0]         last_cnt;

	uvt_ram #(
		.DEPTH (uvt_pkg::CAPACITY),
		.WIDTH (uvt_pkg::VAL_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_xfer = req.valid && req.ready;
	assign last_cnt = count_q - uvt_pkg::CNT_W'(1);
	assign full     = (count_q == uvt_pkg::CNT_W'(uvt_pkg::CAPACITY));
	// scan runs over valid entries only
	assign issue    = (state_q == uvt_pkg::S_SCAN) && (scan_q < count_q);
	assign hit      = (state_q == uvt_pkg::S_SCAN) && pend_s1 && (rd_data == key_q);
	assign hit_last = ({1'b0, pend_idx_s1} == uvt_pkg::CNT_W'({1'b0, last_cnt}));
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			uvt_pkg::S_IDLE: begin
				if (req_xfer) begin
					if (req.operation == uvt_pkg::OP_CONTAINS ||
					    req.operation == uvt_pkg::OP_REMOVE) begin
						state_d = uvt_pkg::S_SCAN;
					end else begin
						state_d = uvt_pkg::S_FINISH;
					end
				end
			end
			uvt_pkg::S_SCAN: begin
				if (hit) begin
					// removing the last entry needs no move
					if (op_q == uvt_pkg::OP_REMOVE && !hit_last) begin
						state_d = uvt_pkg::S_LAST_RD;
					end else begin
						state_d = uvt_pkg::S_FINISH;
					end
				end else if (!issue && !pend_s1) begin
					state_d = uvt_pkg::S_FINISH;
				end
			end
			uvt_pkg::S_LAST_RD: state_d = uvt_pkg::S_MOVE;
			uvt_pkg::S_MOVE:    state_d = uvt_pkg::S_FINISH;
			uvt_pkg::S_FINISH: begin
				if (rsp_free) begin
					state_d = uvt_pkg::S_IDLE;
				end
			end
			default: state_d = uvt_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake and ram controls
	always_comb begin
		req.ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = count_q[uvt_pkg::IDX_W-1:0];
		wr_data   = req.value;
		rd_addr   = scan_q[uvt_pkg::IDX_W-1:0];
		case (state_q)
			uvt_pkg::S_IDLE: begin
				req.ready = 1'b1;
				// add writes straight at the fill position
				wr_en     = req.valid && (req.operation == uvt_pkg::OP_ADD) && !full;
			end
			uvt_pkg::S_LAST_RD: begin
				rd_addr = last_cnt[uvt_pkg::IDX_W-1:0];
			end
			uvt_pkg::S_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.fill_count = rsp_fill_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uvt_pkg::S_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue && !hit;
			if (state_q == uvt_pkg::S_IDLE && req_xfer) begin
				if (req.operation == uvt_pkg::OP_ADD && !full) begin
					count_q <= count_q + uvt_pkg::CNT_W'(1);
				end else if (req.operation == uvt_pkg::OP_CLEAR) begin
					count_q <= '0;
				end
			end else if (hit && op_q == uvt_pkg::OP_REMOVE && hit_last) begin
				count_q <= last_cnt;
			end else if (state_q == uvt_pkg::S_MOVE) begin
				count_q <= last_cnt;
			end
			if (state_q == uvt_pkg::S_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == uvt_pkg::S_IDLE && req_xfer) begin
			op_q   <= uvt_pkg::op_t'(req.operation);
			key_q  <= req.value;
			scan_q <= '0;
			if (req.operation == uvt_pkg::OP_ADD && full) begin
				status_q <= uvt_pkg::ST_FULL;
			end else begin
				status_q <= uvt_pkg::ST_OK;
			end
		end
		if (issue) begin
			scan_q      <= scan_q + uvt_pkg::CNT_W'(1);
			pend_idx_s1 <= scan_q[uvt_pkg::IDX_W-1:0];
		end
		if (hit) begin
			pos_q    <= pend_idx_s1;
			status_q <= uvt_pkg::ST_OK;
		end else if (state_q == uvt_pkg::S_SCAN && !issue && !pend_s1) begin
			status_q <= uvt_pkg::ST_NOT_FOUND;
		end
		if (state_q == uvt_pkg::S_FINISH && rsp_free) begin
			rsp_status_q <= status_q;
			rsp_fill_q   <= uvt_pkg::FILL_W'(count_q);
		end
	end

	// the count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= uvt_pkg::CNT_W'(uvt_pkg::CAPACITY))
		else $error("fill count above capacity");

	// a request transfer always starts work
	assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q != uvt_pkg::S_IDLE)
		else $error("request taken without leaving idle");

	// a finished item always lands in the response register
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == uvt_pkg::S_FINISH && rsp_free) |=> rsp.valid)
		else $error("finished item lost");

	// the hole being filled lies among the valid entries
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == uvt_pkg::S_MOVE |-> {1'b0, pos_q} < count_q)
		else $error("move target outside valid entries");

endmodule

### verif/tb_top.sv
// self-checking testbench for the unsorted value table unit
`timescale 1ns / 1ps

module tb_top;
	import uvt_pkg::*;

	// watchdog limit in clock cycles
	localparam int CYCLE_LIMIT   = 200000;
	// cycles allowed after the last response before the final verdict
	localparam int DRAIN_CYCLES  = 25;
	localparam int RANDOM_ITEMS  = 400;
	// last part of the random run goes without idling on either side
	localparam int QUIET_ITEMS   = 80;

	// scoreboard: tracks the table contents and queues the outcome of every
	// accepted request, then compares responses against that queue in order
	class value_table_scoreboard;
		typedef struct packed {
			status_t             status;
			logic [FILL_W-1:0]   fill_count;
		} outcome_t;

		logic [VAL_W-1:0] slots[CAPACITY];
		int unsigned      live_count;
		outcome_t         expected_outcomes[$];
		int unsigned      failures;

		function new();
			live_count = 0;
			failures   = 0;
		endfunction

		// index of the first live slot holding the key, or live_count if absent
		function int unsigned locate_value(logic [VAL_W-1:0] key);
			for (int unsigned k = 0; k < live_count; k++) begin
				if (slots[k] == key)
					return k;
			end
			return live_count;
		endfunction

		// apply one accepted request and queue the outcome it must produce
		function void note_request(op_t op, logic [VAL_W-1:0] key);
			outcome_t    outcome;
			int unsigned pos;
			outcome.status = ST_OK;
			case (op)
				OP_ADD: begin
					if (live_count >= CAPACITY) begin
						outcome.status = ST_FULL;
					end else begin
						slots[live_count] = key;
						live_count++;
					end
				end
				OP_CONTAINS: begin
					pos = locate_value(key);
					if (pos >= live_count)
						outcome.status = ST_NOT_FOUND;
				end
				OP_REMOVE: begin
					pos = locate_value(key);
					if (pos < live_count) begin
						// the last live entry fills the hole
						slots[pos] = slots[live_count - 1];
						live_count--;
					end else begin
						outcome.status = ST_NOT_FOUND;
					end
				end
				default: begin
					live_count = 0;
				end
			endcase
			outcome.fill_count = live_count[FILL_W-1:0];
			expected_outcomes.push_back(outcome);
		endfunction

		// compare one accepted response with the oldest queued outcome
		function void check_response(logic [STAT_W-1:0] status, logic [FILL_W-1:0] fill);
			outcome_t oldest;
			if (expected_outcomes.size() == 0) begin
				$error("response with nothing pending: status %0d fill_count %0d",
					status, fill);
				failures++;
				return;
			end
			oldest = expected_outcomes.pop_front();
			if (oldest.status !== status) begin
				$error("status: expected %0d, actual %0d", oldest.status, status);
				failures++;
			end
			if (oldest.fill_count !== fill) begin
				$error("fill_count: expected %0d, actual %0d", oldest.fill_count, fill);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_outcomes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	uvt_req_if req_ch();
	uvt_rsp_if rsp_ch();

	unsorted_value_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	value_table_scoreboard table_sb = new();

	// set once the run enters its final stretch; both sides stop idling
	bit quiet_phase;
	int unsigned cycle_count;

	// values that recur often so that contains and remove find hits
	logic [VAL_W-1:0] hot_values[6] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_1234
	};

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a hung handshake or a lost response ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one request transfer; valid stays high into the next item unless a gap
	// is inserted, so valid never sees two assignments in one time step
	task automatic push_request(op_t op, logic [VAL_W-1:0] key);
		int gap;
		if (!quiet_phase && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 3);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.value     <= key;
		// ready read right after the edge is the value the edge sampled
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		table_sb.note_request(op, key);
	endtask

	// mostly hot values, the rest full-width random so every bit toggles
	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return hot_values[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	// op mix leans toward add so the table spends time near and at full
	function automatic op_t pick_op();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return OP_ADD;
		if (roll < 70)
			return OP_CONTAINS;
		if (roll < 96)
			return OP_REMOVE;
		return OP_CLEAR;
	endfunction

	// response side: check each transfer, then decide ready for the next edge
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				table_sb.check_response(rsp_ch.status, rsp_ch.fill_count);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				// start a stall burst that includes this cycle; stall_left holds the rest of it
				stall_left   = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus: reset, directed corner cases, random traffic, drain, verdict
	initial begin
		quiet_phase      = 1'b0;
		cycle_count      = 0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_ADD;
		req_ch.value     = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: clear, lookups that miss, remove from empty
		push_request(OP_CLEAR,    32'h0000_0000);
		push_request(OP_CONTAINS, 32'h0000_0000);
		push_request(OP_REMOVE,   32'hFFFF_FFFF);
		// extremes of the value field
		push_request(OP_ADD,      32'h8000_0000);
		push_request(OP_ADD,      32'h7FFF_FFFF);
		push_request(OP_ADD,      32'hFFFF_FFFF);
		push_request(OP_ADD,      32'h0000_0000);
		push_request(OP_CONTAINS, 32'h7FFF_FFFF);
		push_request(OP_CONTAINS, 32'h0000_0001);
		// remove at the head pulls the last entry forward
		push_request(OP_REMOVE,   32'h8000_0000);
		// remove of the last live entry, which needs no move
		push_request(OP_REMOVE,   32'hFFFF_FFFF);
		push_request(OP_REMOVE,   32'h1234_5678);
		push_request(OP_CLEAR,    32'hFFFF_FFFF);
		// fill to capacity with a duplicate pair, then add to a full table
		for (int i = 0; i < CAPACITY; i++)
			push_request(OP_ADD, (i == CAPACITY - 1) ? 32'h0000_0003 : i * 3);
		push_request(OP_ADD,      32'h5555_AAAA);
		// duplicates: only the first match goes
		push_request(OP_REMOVE,   32'h0000_0003);
		push_request(OP_CONTAINS, 32'h0000_0003);
		push_request(OP_CLEAR,    32'h0000_0000);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet_phase = 1'b1;
			push_request(pick_op(), pick_value());
		end
		@(posedge clk);
		req_ch.valid <= 1'b0;

		// drain, then give the block a few more cycles to show strays
		while (table_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (table_sb.failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
hdl/uvt_pkg.sv
hdl/uvt_req_if.sv
hdl/uvt_rsp_if.sv
hdl/uvt_ram.sv
hdl/unsorted_value_table_unit.sv
verif/tb_top.sv
